[hw/rtl/paged_decay_running_stdev_defines.svh]
// assertion macros for the paged decay running deviation block
// no dependencies; the top level includes this file
`ifndef PAGED_DECAY_RUNNING_STDEV_DEFINES_SVH
`define PAGED_DECAY_RUNNING_STDEV_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define PDRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pdrs check failed");
// checked on every edge, reset included
`define PDRS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("pdrs reset check failed");
`else
`define PDRS_ASSERT(lbl, prop)
`define PDRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hw/rtl/pdrs_pkg.sv]
// shared widths, codes and sequencer states of the paged decay deviation block
// no dependencies
package pdrs_pkg;

    localparam int W_VAL   = 32;
    localparam int W_TIME  = 27;
    localparam int W_MV    = 48;
    localparam int W_MS    = 64;
    localparam int W_DEC   = 16;
    localparam int W_WID   = 8;
    localparam int W_LIM   = 11;
    localparam int W_FAC   = 17;
    localparam int W_SACC  = 52;
    localparam int W_MA    = 48;
    localparam int W_PROD  = W_MA + W_FAC;
    localparam int W_CIDX  = 2;
    localparam int W_CDAT  = 16;

    localparam int DIV_STEPS  = W_TIME;
    localparam int SQRT_STEPS = 32;

    localparam logic [W_FAC-1:0] Q16_ONE  = 17'd65536;
    localparam logic [W_FAC-1:0] Q16_HALF = 17'd32768;

    localparam logic [W_WID-1:0] WIDTH_MIN = 8'd10;
    localparam logic [W_WID-1:0] WIDTH_MAX = 8'd200;
    localparam logic [W_LIM-1:0] LIM_MIN   = 11'd2;
    localparam logic [W_LIM-1:0] LIM_MAX   = 11'd1024;

    localparam logic [W_DEC-1:0] DECAY_RST = 16'd62259;
    localparam logic [W_WID-1:0] WIDTH_RST = 8'd50;
    localparam logic [W_LIM-1:0] LIMIT_RST = 11'd40;

    // configuration register indexes
    localparam logic [W_CIDX-1:0] CFG_DECAY = 2'd0;
    localparam logic [W_CIDX-1:0] CFG_WIDTH = 2'd1;
    localparam logic [W_CIDX-1:0] CFG_LIMIT = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_SQX0, S_SQX1, S_SQL0, S_SQL1, S_BRANCH, S_DIV, S_RST,
        S_SP0, S_SP1, S_SP2, S_SP3, S_POW, S_POWW, S_W0, S_W1,
        S_MV0, S_MV1, S_MV2, S_MV3,
        S_MS0, S_MS1, S_MS2, S_MS3, S_MS4, S_MS5, S_MS6,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_SQRT, S_DONE
    } t_state;

endpackage

[hw/rtl/paged_decay_running_stdev.sv]
// Paths: same-page sample, first sample, page crossing of g pages and restart after a
// long gap; one sample at a time, through the shared 48x17 multiplier and the serial
// divider and square-root steps.
// A finished result waits in the output register while the next sample runs.
// Reset (synchronous, active low) restores the register defaults and unstarted state.
`include "paged_decay_running_stdev_defines.svh"

module paged_decay_running_stdev (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pdrs_pkg::W_CIDX-1:0]   i_cfg_index,
    input  logic [pdrs_pkg::W_CDAT-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [pdrs_pkg::W_VAL-1:0] i_sample_value,
    input  logic [pdrs_pkg::W_TIME-1:0]   i_time_msecs,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pdrs_pkg::W_VAL-1:0]    o_deviation
);
    import pdrs_pkg::*;

    t_state r_state, n_state;

    logic [W_DEC-1:0]  r_cfg_decay;
    logic [W_WID-1:0]  r_cfg_width;
    logic [W_LIM-1:0]  r_cfg_limit;

    logic              r_started;
    logic signed [W_MV-1:0] r_mv;
    logic [W_MS-1:0]   r_ms;
    logic signed [W_VAL-1:0] r_last;
    logic [W_TIME-1:0] r_ps;

    logic signed [W_VAL-1:0] r_x;
    logic [W_TIME-1:0] r_t;
    logic [W_WID-1:0]  r_width;
    logic [W_LIM-1:0]  r_lim;
    logic [W_DEC-1:0]  r_d;
    logic [W_FAC-1:0]  r_inv;
    logic [W_MS-1:0]   r_x2, r_l2, r_acc, r_macc, r_var, r_res, r_bit;
    logic signed [W_SACC-1:0] r_sacc;
    logic [W_PROD-1:0] r_prod;
    logic [W_TIME-1:0] r_dvd, r_quo;
    logic [W_WID-1:0]  r_rem;
    logic              r_div_rst;
    logic [W_LIM-1:0]  r_cnt, r_g;
    logic [W_FAC-1:0]  r_p, r_w;
    logic [W_TIME-1:0] r_sum;
    logic              r_out_valid;
    logic [W_VAL-1:0]  r_dev;

    logic [W_MA-1:0]   mul_a;
    logic [W_FAC-1:0]  mul_b;
    logic [W_MS-1:0]   sub_a, sub_b, sub_d;
    logic              sub_ge;

    // saturating and sign helpers
    function automatic logic [W_MS-1:0] sadd64(input logic [W_MS-1:0] a,
                                               input logic [W_MS-1:0] b);
        logic [W_MS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W_MS] ? {W_MS{1'b1}} : s[W_MS-1:0];
    endfunction

    function automatic logic [W_MV-1:0] sat48(input logic signed [W_SACC-1:0] v);
        if (v[W_SACC-1:W_MV-1] != {(W_SACC-W_MV+1){v[W_SACC-1]}}) begin
            return v[W_SACC-1] ? {1'b1, {(W_MV-1){1'b0}}} : {1'b0, {(W_MV-1){1'b1}}};
        end
        return v[W_MV-1:0];
    endfunction

    function automatic logic signed [W_SACC-1:0] sterm(input logic [W_SACC-1:0] mag,
                                                       input logic neg);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // operand magnitudes and differences
    logic [W_VAL-1:0]  x_mag, l_mag, xl_mag;
    logic [W_VAL:0]    xl_diff;
    logic              xl_neg;
    logic [W_MV-1:0]   mv_mag;
    logic              sq_ge;
    logic [W_MS-1:0]   sq_dif;
    logic [W_TIME-1:0] t_diff;
    logic              same_page;
    logic [W_PROD-1:0] rnd_sum;
    logic [W_MS-1:0]   prod_rnd, prod_sh16, msq;
    logic [W_WID:0]    div_sh;
    logic [W_WID-1:0]  rem_next;
    logic [W_TIME-1:0] quo_next;
    logic [W_FAC-1:0]  pn;
    logic [W_WID-1:0]  width_c;
    logic [W_LIM-1:0]  lim_c;

    assign x_mag     = r_x[W_VAL-1] ? (~r_x + 1'b1) : r_x;
    assign l_mag     = r_last[W_VAL-1] ? (~r_last + 1'b1) : r_last;
    assign xl_diff   = {r_x[W_VAL-1], r_x} - {r_last[W_VAL-1], r_last};
    assign xl_neg    = xl_diff[W_VAL];
    assign xl_mag    = xl_neg ? W_VAL'(~xl_diff + 1'b1) : xl_diff[W_VAL-1:0];
    assign mv_mag    = r_mv[W_MV-1] ? (~r_mv + 1'b1) : r_mv;
    assign sq_ge     = r_x2 >= r_l2;
    assign sq_dif    = sq_ge ? (r_x2 - r_l2) : (r_l2 - r_x2);
    assign t_diff    = r_t - r_ps;
    assign same_page = (r_t < r_ps) || (t_diff < W_TIME'(r_width));
    assign rnd_sum   = r_prod + W_PROD'(Q16_HALF);
    assign prod_rnd  = W_MS'(rnd_sum[W_PROD-1:16]);
    assign prod_sh16 = {r_prod[W_MS-17:0], 16'h0000};
    assign pn        = prod_rnd[W_FAC-1:0];
    assign msq       = r_macc + (({r_acc[W_MS-2:0], 1'b0}
                       + W_MS'(r_prod[31:16])) >> 16);

    // divider step
    assign div_sh   = {r_rem, r_dvd[W_TIME-1]};
    assign rem_next = sub_ge ? sub_d[W_WID-1:0] : div_sh[W_WID-1:0];
    assign quo_next = {r_quo[W_TIME-2:0], sub_ge};

    // clamp configuration at sample transfer
    assign width_c = (r_cfg_width < WIDTH_MIN) ? WIDTH_MIN :
                     (r_cfg_width > WIDTH_MAX) ? WIDTH_MAX : r_cfg_width;
    assign lim_c   = (r_cfg_limit < LIM_MIN) ? LIM_MIN :
                     (r_cfg_limit > LIM_MAX) ? LIM_MAX : r_cfg_limit;

    // shared subtract and compare unit
    assign sub_d  = sub_a - sub_b;
    assign sub_ge = sub_a >= sub_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SQX0;
            S_SQX0:   n_state = S_SQX1;
            S_SQX1:   n_state = S_SQL0;
            S_SQL0:   n_state = S_SQL1;
            S_SQL1:   n_state = S_BRANCH;
            S_BRANCH: begin
                if (!r_started) n_state = S_DIV;
                else if (same_page) n_state = S_SP0;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == W_LIM'(DIV_STEPS - 1)) begin
                    if (r_div_rst) n_state = S_RST;
                    else if (quo_next >= W_TIME'(r_lim)) n_state = S_DIV;
                    else n_state = S_POW;
                end
            end
            S_RST:    n_state = S_Q0;
            S_SP0:    n_state = S_SP1;
            S_SP1:    n_state = S_SP2;
            S_SP2:    n_state = S_SP3;
            S_SP3:    n_state = S_Q0;
            S_POW:    n_state = S_POWW;
            S_POWW:   n_state = (r_cnt == r_g) ? S_W0 : S_POW;
            S_W0:     n_state = S_W1;
            S_W1:     n_state = S_MV0;
            S_MV0:    n_state = S_MV1;
            S_MV1:    n_state = S_MV2;
            S_MV2:    n_state = S_MV3;
            S_MV3:    n_state = S_MS0;
            S_MS0:    n_state = S_MS1;
            S_MS1:    n_state = S_MS2;
            S_MS2:    n_state = S_MS3;
            S_MS3:    n_state = S_MS4;
            S_MS4:    n_state = S_MS5;
            S_MS5:    n_state = S_MS6;
            S_MS6:    n_state = S_Q0;
            S_Q0:     n_state = S_Q1;
            S_Q1:     n_state = S_Q2;
            S_Q2:     n_state = S_Q3;
            S_Q3:     n_state = S_Q4;
            S_Q4:     n_state = S_SQRT;
            S_SQRT:   if (r_cnt == W_LIM'(SQRT_STEPS - 1)) n_state = S_DONE;
            S_DONE:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // operand selection for the shared units
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sub_a = '0;
        sub_b = '0;
        case (r_state)
            S_SQX0: begin mul_a = W_MA'(x_mag); mul_b = W_FAC'(x_mag[15:0]); end
            S_SQX1: begin mul_a = W_MA'(x_mag); mul_b = W_FAC'(x_mag[31:16]); end
            S_SQL0: begin mul_a = W_MA'(l_mag); mul_b = W_FAC'(l_mag[15:0]); end
            S_SQL1: begin mul_a = W_MA'(l_mag); mul_b = W_FAC'(l_mag[31:16]); end
            S_DIV: begin sub_a = W_MS'(div_sh); sub_b = W_MS'(r_width); end
            S_SP0: begin mul_a = W_MA'(xl_mag); mul_b = r_inv; end
            S_SP1: begin mul_a = sq_dif[63:16]; mul_b = r_inv; end
            S_SP2: begin mul_a = W_MA'(sq_dif[15:0]); mul_b = r_inv; end
            S_POW: begin mul_a = W_MA'(r_p); mul_b = W_FAC'(r_d); end
            S_W0:  begin mul_a = W_MA'(r_sum); mul_b = r_inv; end
            S_MV0: begin mul_a = W_MA'(x_mag); mul_b = r_inv; end
            S_MV1: begin mul_a = W_MA'(l_mag); mul_b = r_w; end
            S_MV2: begin mul_a = mv_mag; mul_b = r_p; end
            S_MS0: begin mul_a = r_x2[63:16]; mul_b = r_inv; end
            S_MS1: begin mul_a = W_MA'(r_x2[15:0]); mul_b = r_inv; end
            S_MS2: begin mul_a = r_l2[63:16]; mul_b = r_w; end
            S_MS3: begin mul_a = W_MA'(r_l2[15:0]); mul_b = r_w; end
            S_MS4: begin mul_a = r_ms[63:16]; mul_b = r_p; end
            S_MS5: begin mul_a = W_MA'(r_ms[15:0]); mul_b = r_p; end
            S_Q0:  begin mul_a = W_MA'(mv_mag[47:16]); mul_b = W_FAC'(mv_mag[31:16]); end
            S_Q1:  begin mul_a = W_MA'(mv_mag[47:16]); mul_b = W_FAC'(mv_mag[47:32]); end
            S_Q2:  begin mul_a = W_MA'(mv_mag[47:16]); mul_b = W_FAC'(mv_mag[15:0]); end
            S_Q3:  begin mul_a = W_MA'(mv_mag[15:0]); mul_b = W_FAC'(mv_mag[15:0]); end
            S_SQRT: begin sub_a = r_var; sub_b = r_res + r_bit; end
            default: begin end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_decay <= DECAY_RST;
            r_cfg_width <= WIDTH_RST;
            r_cfg_limit <= LIMIT_RST;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY: r_cfg_decay <= i_cfg_data[W_DEC-1:0];
                    CFG_WIDTH: r_cfg_width <= i_cfg_data[W_WID-1:0];
                    CFG_LIMIT: r_cfg_limit <= i_cfg_data[W_LIM-1:0];
                    default: begin end
                endcase
            end
            if (r_state == S_RST || r_state == S_MS6) r_started <= 1'b1;
            // output register: load on finish, clear on result transfer
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= {{W_FAC{1'b0}}, mul_a} * {{W_MA{1'b0}}, mul_b};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_x     <= i_sample_value;
                    r_t     <= i_time_msecs;
                    r_width <= width_c;
                    r_lim   <= lim_c;
                    r_d     <= r_cfg_decay;
                    r_inv   <= Q16_ONE - W_FAC'(r_cfg_decay);
                end
            end
            S_SQX1: r_acc <= r_prod[W_MS-1:0];
            S_SQL0: r_x2 <= prod_sh16 + r_acc;
            S_SQL1: r_acc <= r_prod[W_MS-1:0];
            S_BRANCH: begin
                r_l2      <= prod_sh16 + r_acc;
                r_dvd     <= r_started ? t_diff : r_t;
                r_div_rst <= !r_started;
                r_rem     <= '0;
                r_quo     <= '0;
                r_cnt     <= '0;
            end
            // one quotient bit per cycle
            S_DIV: begin
                r_rem <= rem_next;
                r_quo <= quo_next;
                r_dvd <= {r_dvd[W_TIME-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_LIM'(DIV_STEPS - 1) && !r_div_rst) begin
                    if (quo_next >= W_TIME'(r_lim)) begin
                        r_dvd     <= r_t;
                        r_div_rst <= 1'b1;
                        r_rem     <= '0;
                        r_quo     <= '0;
                        r_cnt     <= '0;
                    end else begin
                        r_g   <= quo_next[W_LIM-1:0];
                        r_p   <= Q16_ONE;
                        r_sum <= '0;
                        r_cnt <= W_LIM'(1);
                    end
                end
            end
            // first sample or restart
            S_RST: begin
                r_mv <= {r_x, 16'h0000};
                r_ms <= r_x2;
                r_ps <= r_t - W_TIME'(r_rem);
            end
            // same page: replace last sample's share
            S_SP1: r_mv <= sat48({{(W_SACC-W_MV){r_mv[W_MV-1]}}, r_mv}
                               + sterm(r_prod[W_SACC-1:0], xl_neg));
            S_SP2: r_acc <= r_prod[W_MS-1:0];
            S_SP3: begin
                if (sq_ge) r_ms <= sadd64(r_ms, r_acc + prod_rnd);
                else if ((r_acc + prod_rnd) > r_ms) r_ms <= '0;
                else r_ms <= r_ms - (r_acc + prod_rnd);
            end
            // decay power and skipped-page sum
            S_POWW: begin
                r_p <= pn;
                if (r_cnt < r_g) r_sum <= r_sum + W_TIME'(pn);
                if (r_cnt != r_g) r_cnt <= r_cnt + 1'b1;
            end
            S_W1: r_w <= (prod_rnd > W_MS'(Q16_ONE)) ? Q16_ONE : pn;
            S_MV1: r_sacc <= sterm(r_prod[W_SACC-1:0], r_x[W_VAL-1]);
            S_MV2: r_sacc <= r_sacc + sterm(r_prod[W_SACC-1:0], r_last[W_VAL-1]);
            S_MV3: r_mv <= sat48(r_sacc + sterm(prod_rnd[W_SACC-1:0], r_mv[W_MV-1]));
            S_MS1: r_acc <= r_prod[W_MS-1:0];
            S_MS2: r_macc <= r_acc + prod_rnd;
            S_MS3: r_acc <= r_prod[W_MS-1:0];
            S_MS4: r_macc <= sadd64(r_macc, r_acc + prod_rnd);
            S_MS5: r_acc <= r_prod[W_MS-1:0];
            S_MS6: begin
                r_ms <= sadd64(r_macc, r_acc + prod_rnd);
                r_ps <= r_t - W_TIME'(r_rem);
            end
            // squared mean
            S_Q0: r_last <= r_x;
            S_Q1: r_acc <= r_prod[W_MS-1:0];
            S_Q2: r_macc <= prod_sh16 + r_acc;
            S_Q3: r_acc <= r_prod[W_MS-1:0];
            S_Q4: begin
                r_var <= (r_ms > msq) ? (r_ms - msq) : '0;
                r_res <= '0;
                r_bit <= {2'b01, {(W_MS-2){1'b0}}};
                r_cnt <= '0;
            end
            // one result bit per cycle
            S_SQRT: begin
                if (sub_ge) begin
                    r_var <= sub_d;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: if (!r_out_valid || i_out_ready) r_dev <= r_res[W_VAL-1:0];
            default: begin end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_deviation = r_dev;

    // checks
    `PDRS_ASSERT(a_busy_after_xfer, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `PDRS_ASSERT(a_pow_bounded, (r_state == S_POW) |-> (r_p <= Q16_ONE))
    `PDRS_ASSERT(a_rem_below_width, (r_state == S_DIV) |-> (r_rem < r_width))
    `PDRS_ASSERT(a_sqrt_bit_onehot, (r_state == S_SQRT) |-> $onehot(r_bit))
    `PDRS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid))

endmodule

[sim/testbench.sv]
// self-checking testbench for the paged decay running deviation block
// depends on pdrs_pkg and the paged_decay_running_stdev top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pdrs_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 830;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [W_CIDX-1:0] i_cfg_index = '0;
    logic [W_CDAT-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [W_VAL-1:0] i_sample_value = '0;
    logic [W_TIME-1:0] i_time_msecs = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [W_VAL-1:0] o_deviation;

    paged_decay_running_stdev u_dut (.*);

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        logic signed [W_VAL-1:0] value;
        logic [W_TIME-1:0] stamp;
    } t_sample;

    t_sample sample_q[$];
    logic [W_VAL-1:0] dev_q[$];
    bit quiet_tail = 0;
    int n_mismatch = 0, n_checked = 0, n_sent = 0, idle_cycles = 0;
    bit timed_out = 0;

    // predictor state and configuration
    logic [15:0] cf_decay;
    logic [7:0]  cf_width;
    logic [10:0] cf_limit;
    bit pr_started;
    longint pr_mean;
    longint unsigned pr_msq;
    longint pr_last;
    longint unsigned pr_page;

    function automatic longint sat48(longint v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint unsigned scale_u(longint unsigned a, longint unsigned f);
        return (a >> 16) * f + (((a & 64'hFFFF) * f + 64'd32768) >> 16);
    endfunction

    function automatic longint scale_s(longint m, longint unsigned f);
        longint unsigned r;
        r = (mag(m) * f + 64'd32768) >> 16;
        return m < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic void restart_means(longint x, longint unsigned t, longint unsigned w);
        pr_mean = x * 65536;
        pr_msq = mag(x) * mag(x);
        pr_page = t - (t % w);
    endfunction

    // advance the predicted state by one sample and return the deviation
    function automatic logic [31:0] predict_deviation(t_sample s);
        longint x;
        longint unsigned t, w, lim, d, inv, x2, l2, g, p, acc, wt, dn, q, qh, ql, sq, var_v;
        x = longint'(s.value);
        t = s.stamp;
        w = cf_width < 10 ? 10 : (cf_width > 200 ? 200 : cf_width);
        lim = cf_limit < 2 ? 2 : (cf_limit > 1024 ? 1024 : cf_limit);
        d = cf_decay;
        inv = 65536 - d;
        x2 = mag(x) * mag(x);
        l2 = mag(pr_last) * mag(pr_last);
        if (!pr_started) begin
            pr_started = 1;
            restart_means(x, t, w);
        end else if (t < pr_page || t - pr_page < w) begin
            pr_mean = sat48(pr_mean + longint'(inv) * (x - pr_last));
            if (x2 >= l2) pr_msq = add_sat(pr_msq, scale_u(x2 - l2, inv));
            else begin
                dn = scale_u(l2 - x2, inv);
                pr_msq = dn > pr_msq ? 0 : pr_msq - dn;
            end
        end else begin
            g = (t - pr_page) / w;
            if (g >= lim) restart_means(x, t, w);
            else begin
                p = 65536;
                acc = 0;
                for (longint unsigned i = 1; i <= g; i++) begin
                    p = (p * d + 32768) >> 16;
                    if (i < g) acc += p;
                end
                wt = (inv * acc + 32768) >> 16;
                if (wt > 65536) wt = 65536;
                pr_mean = sat48(longint'(inv) * x + longint'(wt) * pr_last
                                + scale_s(pr_mean, p));
                pr_msq = add_sat(add_sat(scale_u(x2, inv), scale_u(l2, wt)),
                                 scale_u(pr_msq, p));
                pr_page += g * w;
            end
        end
        pr_last = x;
        q = mag(pr_mean);
        qh = q >> 16;
        ql = q & 64'hFFFF;
        sq = qh * qh + ((2 * qh * ql + ((ql * ql) >> 16)) >> 16);
        var_v = pr_msq > sq ? pr_msq - sq : 0;
        return root_floor(var_v);
    endfunction

    // input driver with random gaps
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            dev_q.push_back(predict_deviation({i_sample_value, i_time_msecs}));
            n_sent++;
        end
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() > 0 && i_rst_n) begin
                i_in_valid <= 1'b1;
                {i_sample_value, i_time_msecs} <= sample_q.pop_front();
                if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (dev_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected transfer: deviation %h", o_deviation);
            end else begin
                logic [31:0] exp_dev;
                exp_dev = dev_q.pop_front();
                n_checked++;
                if (o_deviation !== exp_dev) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("deviation mismatch: expected %h actual %h", exp_dev, o_deviation);
                end
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n;
            if (!quiet_tail && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 15);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic settle();
        while (sample_q.size() > 0 || i_in_valid || dev_q.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // one register write, then the write port is held quiet before returning
    task automatic write_reg(logic [W_CIDX-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DECAY: cf_decay = val;
            CFG_WIDTH: cf_width = val[7:0];
            CFG_LIMIT: cf_limit = val[10:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_sample mk(logic [31:0] v, logic [26:0] t);
        t_sample s;
        s.value = v;
        s.stamp = t;
        return s;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // random run of samples with mostly advancing time
    task automatic random_phase(int n, ref logic [26:0] clock_ms);
        int step;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: step = $urandom_range(0, 60);
                4, 5, 6: step = $urandom_range(50, 600);
                7: step = $urandom_range(0, 3000);
                8: step = -$urandom_range(0, 200);
                default: step = $urandom_range(0, 60000);
            endcase
            if ($urandom_range(0, 60) == 0) clock_ms = 27'($urandom_range(0, 86399999));
            else if (int'(clock_ms) + step > 86399999 || int'(clock_ms) + step < 0)
                clock_ms = 27'd1000;
            else clock_ms = 27'(int'(clock_ms) + step);
            sample_q.push_back(mk(rand_value(), clock_ms));
        end
    endtask

    initial begin
        logic [26:0] clock_ms;
        cf_decay = DECAY_RST;
        cf_width = WIDTH_RST;
        cf_limit = LIMIT_RST;
        pr_started = 0;
        pr_mean = 0;
        pr_msq = 0;
        pr_last = 0;
        pr_page = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first sample, same page, backwards time, crossings, restart
        sample_q.push_back(mk(32'h0001_0000, 27'd1234));
        sample_q.push_back(mk(32'h7FFF_FFFF, 27'd1240));
        sample_q.push_back(mk(32'h8000_0000, 27'd1249));
        sample_q.push_back(mk(32'h0000_0000, 27'd1000));
        sample_q.push_back(mk(32'hFFFF_FFFF, 27'd1260));
        sample_q.push_back(mk(32'h0003_0000, 27'd1420));
        sample_q.push_back(mk(32'hFFFE_0000, 27'd3100));
        sample_q.push_back(mk(32'h0005_0000, 27'd9000));
        sample_q.push_back(mk(32'h0000_1000, 27'd86399999));
        sample_q.push_back(mk(32'h0000_2000, 27'h7FF_FFFF));
        settle();

        // extremes of every register: zero decay and out-of-range clamps
        write_reg(CFG_DECAY, 16'd0);
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_LIMIT, 16'h07FF);
        sample_q.push_back(mk(32'h0002_0000, 27'd100000));
        sample_q.push_back(mk(32'h0004_0000, 27'd100700));
        sample_q.push_back(mk(32'hFFF0_0000, 27'd300000));
        settle();
        write_reg(CFG_DECAY, 16'hFFFF);
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_LIMIT, 16'd0);
        sample_q.push_back(mk(32'h0002_0000, 27'd500000));
        sample_q.push_back(mk(32'h0009_0000, 27'd500015));
        sample_q.push_back(mk(32'h0001_0000, 27'd500021));
        sample_q.push_back(mk(32'h0001_0000, 27'd500090));
        settle();

        // random phases across several settings
        clock_ms = 27'd2000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_DECAY, DECAY_RST); write_reg(CFG_WIDTH, 16'd10);
                         write_reg(CFG_LIMIT, 16'd1024); end
                1: begin write_reg(CFG_DECAY, 16'd1); write_reg(CFG_WIDTH, 16'd200);
                         write_reg(CFG_LIMIT, 16'd2); end
                2: begin write_reg(CFG_DECAY, 16'd65535); write_reg(CFG_WIDTH, 16'd50);
                         write_reg(CFG_LIMIT, 16'd40); end
                default: begin write_reg(CFG_DECAY, 16'($urandom));
                         write_reg(CFG_WIDTH, 16'($urandom_range(10, 200)));
                         write_reg(CFG_LIMIT, 16'($urandom_range(2, 300))); end
            endcase
            if (ph == 5) quiet_tail = 1;
            random_phase(N_RANDOM / 6, clock_ms);
            settle();
        end

        $display("sent %0d samples, checked %0d deviations over several register settings",
                 n_sent, n_checked);
        if (n_mismatch == 0 && dev_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
